/* rtl/latlon_to_unit_vector_top_defines.svh */
// Assertion macros for the checker file of the lat/lon unit vector block.
`ifndef LATLON_TO_UNIT_VECTOR_TOP_DEFINES_SVH
`define LATLON_TO_UNIT_VECTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LLUV_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LLUV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lluv_pkg.sv */
// Shared types and constants of the lat/lon unit vector block.
package lluv_pkg;

	localparam int IN_W         = 64;
	localparam int OUT_W        = 96;
	localparam int FIELD_W      = 32;
	localparam int CORDIC_STEPS = 32;
	localparam int COR_STAGES   = CORDIC_STEPS / 2;
	localparam int INNER_FRAC   = 40;
	localparam int TRIG_FRAC    = 30;
	localparam int XY_W         = 43;
	localparam int Z_W          = 34;

	typedef logic signed [XY_W-1:0]    xy_t;
	typedef logic signed [Z_W-1:0]     z_t;
	typedef logic signed [FIELD_W-1:0] trig_t;
	typedef logic signed [63:0]        prod_t;

	typedef struct packed {
		xy_t x;
		xy_t y;
		z_t  z;
	} cor_t;

	typedef struct packed {
		cor_t       c;
		logic [1:0] q;
	} prep_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} sc_t;

	// 0.60725293500888 in 40 fraction bits
	localparam xy_t GAIN_Q40 = 43'sd667681663043;

	// atan(2^-i), 2^32 = full turn
	localparam z_t ATAN_TURN [CORDIC_STEPS] = '{
		34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
		34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
		34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
		34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
		34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
		34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051,
		34'sh00000029, 34'sh00000014, 34'sh0000000A, 34'sh00000005,
		34'sh00000003, 34'sh00000001, 34'sh00000001, 34'sh00000000
	};

endpackage

/* rtl/latlon_to_unit_vector_top.sv */
// Streaming lat/lon to unit vector converter: two CORDIC pipelines and a product stage.
//
//  channel  dir  payload (low bit up)                     handshake
//  s_*      in   latitude[31:0], longitude[63:32]         s_tvalid/s_tready
//  m_*      out  coord_x[31:0], coord_y[63:32], z[95:64]  m_tvalid/m_tready
//
// One request per clock sustained while m_tready does not stall the output; the pipe is a
// prep stage, sixteen CORDIC stages of two iterations each, a round/quadrant stage, a 32x32
// multiply stage and the output rounding register.
// arst_n clears the valid bits only; payload registers are not reset.
// A stall at m_tready freezes the whole pipe, s_tready follows it in the same cycle.
module latlon_to_unit_vector_top #(
	parameter int ANGLE_BITS = 32,
	parameter int FRAC_BITS  = 30
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [lluv_pkg::IN_W-1:0] s_tdata,   // latitude, longitude
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [lluv_pkg::OUT_W-1:0] m_tdata   // coord_x, coord_y, coord_z
);
	import lluv_pkg::*;

	localparam int    TurnShift = 32 - ANGLE_BITS;
	localparam int    ZShift    = TRIG_FRAC - FRAC_BITS;
	localparam int    PShift    = 2 * TRIG_FRAC - FRAC_BITS;
	localparam int    TrigShift = INNER_FRAC - TRIG_FRAC;
	localparam trig_t RoundZ    = (32'sd1 <<< ZShift) >>> 1;
	localparam prod_t RoundP    = 64'sd1 <<< (PShift - 1);
	localparam xy_t   RoundT    = 43'sd1 <<< (TrigShift - 1);
	localparam xy_t   OneT      = 43'sd1 <<< TRIG_FRAC;

	function automatic prep_t prep(logic [FIELD_W-1:0] f);
		logic [31:0] a;
		logic [31:0] qa;
		logic [31:0] d;
		prep_t       p;
		a      = 32'(f[ANGLE_BITS-1:0]) << TurnShift;
		qa     = a + 32'h2000_0000;
		p.q    = qa[31:30];
		d      = a - {p.q, 30'b0};
		p.c.x  = GAIN_Q40;
		p.c.y  = '0;
		p.c.z  = Z_W'(signed'(d));
		return p;
	endfunction

	function automatic cor_t cor_iter(cor_t c, logic [4:0] i);
		xy_t  xs;
		xy_t  ys;
		cor_t r;
		xs = c.x >>> i;
		ys = c.y >>> i;
		if (!c.z[Z_W-1]) begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - ATAN_TURN[i];
		end else begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + ATAN_TURN[i];
		end
		return r;
	endfunction

	function automatic trig_t round_clamp(xy_t v);
		xy_t r;
		r = (v + RoundT) >>> TrigShift;
		if (r > OneT) begin
			r = OneT;
		end else if (r < -OneT) begin
			r = -OneT;
		end
		return trig_t'(r);
	endfunction

	function automatic sc_t post(cor_t c, logic [1:0] q);
		trig_t co;
		trig_t si;
		sc_t   o;
		co = round_clamp(c.x);
		si = round_clamp(c.y);
		unique case (q)
			2'd0: begin o.c = co;  o.s = si;  end
			2'd1: begin o.c = -si; o.s = co;  end
			2'd2: begin o.c = -co; o.s = -si; end
			2'd3: begin o.c = si;  o.s = -co; end
		endcase
		return o;
	endfunction

	logic adv;

	logic       v_s1;
	cor_t       lat_s1, lon_s1;
	logic [1:0] latq_s1, lonq_s1;

	logic       v_s2    [COR_STAGES];
	cor_t       lat_s2  [COR_STAGES];
	cor_t       lon_s2  [COR_STAGES];
	logic [1:0] latq_s2 [COR_STAGES];
	logic [1:0] lonq_s2 [COR_STAGES];

	logic  v_s3;
	sc_t   lat_s3, lon_s3;

	logic  v_s4;
	prod_t px_s4, py_s4;
	trig_t z_s4;

	logic  v_s5;
	trig_t x_s5, y_s5, z_s5;

	prep_t lat_p, lon_p;
	sc_t   lat_sc, lon_sc;

	assign adv      = !v_s5 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s5;
	assign m_tdata  = {z_s5, y_s5, x_s5};

	assign lat_p  = prep(s_tdata[FIELD_W-1:0]);
	assign lon_p  = prep(s_tdata[2*FIELD_W-1:FIELD_W]);
	assign lat_sc = post(lat_s2[COR_STAGES-1], latq_s2[COR_STAGES-1]);
	assign lon_sc = post(lon_s2[COR_STAGES-1], lonq_s2[COR_STAGES-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s3 <= v_s2[COR_STAGES-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lat_s1  <= lat_p.c;
			lon_s1  <= lon_p.c;
			latq_s1 <= lat_p.q;
			lonq_s1 <= lon_p.q;
			lat_s3  <= lat_sc;
			lon_s3  <= lon_sc;
			px_s4   <= lon_s3.c * lat_s3.c;
			py_s4   <= lon_s3.s * lat_s3.c;
			z_s4    <= (lat_s3.s + RoundZ) >>> ZShift;
			x_s5    <= trig_t'((px_s4 + RoundP) >>> PShift);
			y_s5    <= trig_t'((py_s4 + RoundP) >>> PShift);
			z_s5    <= z_s4;
		end
	end

	for (genvar k = 0; k < COR_STAGES; k++) begin : g_cor
		logic       vin;
		cor_t       lat_in, lon_in;
		logic [1:0] latq_in, lonq_in;

		if (k == 0) begin : g_first
			assign vin     = v_s1;
			assign lat_in  = lat_s1;
			assign lon_in  = lon_s1;
			assign latq_in = latq_s1;
			assign lonq_in = lonq_s1;
		end else begin : g_next
			assign vin     = v_s2[k-1];
			assign lat_in  = lat_s2[k-1];
			assign lon_in  = lon_s2[k-1];
			assign latq_in = latq_s2[k-1];
			assign lonq_in = lonq_s2[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (adv) begin
				v_s2[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lat_s2[k]  <= cor_iter(cor_iter(lat_in, 5'(2 * k)), 5'(2 * k + 1));
				lon_s2[k]  <= cor_iter(cor_iter(lon_in, 5'(2 * k)), 5'(2 * k + 1));
				latq_s2[k] <= latq_in;
				lonq_s2[k] <= lonq_in;
			end
		end
	end

endmodule

/* rtl/lluv_check.sv */
// Port-level assertion checker for the lat/lon unit vector block, with its bind.
`include "latlon_to_unit_vector_top_defines.svh"

module lluv_check #(
	parameter int FRAC_BITS = 30
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [lluv_pkg::IN_W-1:0]  s_tdata,    // latitude, longitude
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [lluv_pkg::OUT_W-1:0] m_tdata     // coord_x, coord_y, coord_z
);
	import lluv_pkg::*;

	localparam trig_t One = 32'sd1 <<< FRAC_BITS;

	trig_t cx, cy, cz;
	assign cx = trig_t'(m_tdata[FIELD_W-1:0]);
	assign cy = trig_t'(m_tdata[2*FIELD_W-1:FIELD_W]);
	assign cz = trig_t'(m_tdata[3*FIELD_W-1:2*FIELD_W]);

	// waiting request stays put
	`LLUV_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "request changed")
	// held result must not change or drop
	`LLUV_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed under stall")
	// input side only stalls while a result is held back
	`LLUV_ASSERT_IMPL(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready), "s_tready does not follow output stall")
	// z is a sine
	`LLUV_ASSERT_IMPL(a_z_range, m_tvalid, cz <= One && cz >= -One, "coord_z out of unit range")
	// x and y are products of two unit-bounded values
	`LLUV_ASSERT_IMPL(a_xy_range, m_tvalid, cx <= One && cx >= -One && cy <= One && cy >= -One, "coord_x or coord_y out of unit range")

endmodule

bind latlon_to_unit_vector_top lluv_check #(.FRAC_BITS(FRAC_BITS)) u_check (.*);
